[rtl/core/mbc_pkg.sv]
// Shared types, constants and helpers for the maze backtracker carver.
// No dependencies; every core file refers to it by scoped names.

package mbc_pkg;

   // grid geometry (the side must be a power of two: cell index is {y, x})
   localparam int GRID_SIDE  = 32;
   localparam int COORD_W    = $clog2(GRID_SIDE);
   localparam int CELL_W     = 2 * COORD_W;
   localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
   localparam int LEVEL_W    = CELL_W + 1;

   // request field widths
   localparam int RND_W = 8;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = COORD_W;
   localparam logic [CSR_IDX_W-1:0] CSR_START_X = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y = 1'd1;
   localparam logic [COORD_W-1:0]   START_X_RESET = COORD_W'(10);
   localparam logic [COORD_W-1:0]   START_Y_RESET = COORD_W'(10);

   // request modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   // wall directions
   localparam logic [1:0] DIR_LEFT  = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_UP    = 2'd2;
   localparam logic [1:0] DIR_DOWN  = 2'd3;

   typedef logic [GRID_SIDE-1:0] row_type;
   typedef logic [CELL_W-1:0]    cell_type;

   // access to the visited map, one row per address
   typedef struct packed {
      logic                rd_en;
      logic [COORD_W-1:0]  rd_row;
      logic                wr_en;
      logic [COORD_W-1:0]  wr_row;
      row_type             wr_data;
      logic                clear_all;
   } map_req_type;

   // random byte mod 3: base-4 digits sum to the same residue
   function automatic logic [1:0] mod3_byte(input logic [RND_W-1:0] v);
      logic [3:0] s;
      s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
      if (s >= 4'd9)
         s = s - 4'd9;
      else if (s >= 4'd6)
         s = s - 4'd6;
      if (s >= 4'd3)
         s = s - 4'd3;
      return s[1:0];
   endfunction

endpackage

[rtl/core/mbc_visit_map.sv]
// Visited map of the maze carver: one grid row per memory word.
// Per-row valid flags make a cleared row read as zero. Uses mbc_pkg.

module mbc_visit_map (
   input  logic                clock,
   input  logic                reset,
   input  mbc_pkg::map_req_type req,
   output mbc_pkg::row_type    rd_data
);

   mbc_pkg::row_type mem [mbc_pkg::GRID_SIDE];

   logic [mbc_pkg::GRID_SIDE-1:0] row_valid_ff, row_valid_in;
   mbc_pkg::row_type              rd_data_ff;
   logic                          rd_valid_ff;

   // valid flags: clear on start, set on any row write
   always_comb begin
      row_valid_in = req.clear_all ? '0 : row_valid_ff;
      if (req.wr_en)
         row_valid_in[req.wr_row] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         row_valid_ff <= '0;
      else
         row_valid_ff <= row_valid_in;
   end

   // row storage, registered read
   always_ff @(posedge clock) begin
      if (req.wr_en)
         mem[req.wr_row] <= req.wr_data;
      if (req.rd_en) begin
         rd_data_ff  <= mem[req.rd_row];
         rd_valid_ff <= row_valid_ff[req.rd_row];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

[rtl/core/mbc_stack_ram.sv]
// Path stack storage: one cell index per level, one write and one read port.
// Read data is registered. Uses mbc_pkg.

module mbc_stack_ram (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [mbc_pkg::CELL_W-1:0] wr_addr,
   input  mbc_pkg::cell_type      wr_data,
   input  logic                   rd_en,
   input  logic [mbc_pkg::CELL_W-1:0] rd_addr,
   output mbc_pkg::cell_type      rd_data
);

   mbc_pkg::cell_type mem [mbc_pkg::CELL_COUNT];
   mbc_pkg::cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/maze_backtracker_carver_core.sv]
// Top level of the maze carver: sequencer, config registers, result register.
// Instantiates mbc_visit_map and mbc_stack_ram; uses mbc_pkg.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_mode, req_random_byte
//   rsp      out        rsp_valid/rsp_ready  from_x, from_y, direction, carved, finished
//   csr      in         csr_wr_en            csr_index, csr_wr_data
//
// A start request is accepted in IDLE and registers its result in LAUNCH; a step
// goes on through TOP, ROWC, ROWU and EVAL, and each dead-end cell popped repeats
// TOP, ROWC, ROWU and EVAL, as the visited map has a single read port: three row
// reads per examined cell. A new request is taken the cycle after the previous
// result is registered. Synchronous reset clears the map's row flags at once; no
// clearing pass. A stalled rsp channel holds the sequencer in its final state.

module maze_backtracker_carver_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_mode,
   input  logic [mbc_pkg::RND_W-1:0]       req_random_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mbc_pkg::COORD_W-1:0]     rsp_from_x,
   output logic [mbc_pkg::COORD_W-1:0]     rsp_from_y,
   output logic [1:0]                      rsp_direction,
   output logic                            rsp_carved,
   output logic                            rsp_finished,
   input  logic                            csr_wr_en,
   input  logic [mbc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mbc_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int CW = mbc_pkg::COORD_W;
   localparam int LW = mbc_pkg::LEVEL_W;
   localparam logic [CW-1:0] MAX_COORD = CW'(mbc_pkg::GRID_SIDE - 1);
   localparam logic [LW-1:0] LEVEL_FULL = LW'(mbc_pkg::CELL_COUNT);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LAUNCH = 3'd1;
   localparam logic [2:0] S_TOP    = 3'd2;
   localparam logic [2:0] S_ROWC   = 3'd3;
   localparam logic [2:0] S_ROWU   = 3'd4;
   localparam logic [2:0] S_EVAL   = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic          mode_ff, mode_in;
   logic [mbc_pkg::RND_W-1:0] rnd_ff, rnd_in;
   logic [1:0]    rnd_mod3_ff, rnd_mod3_in;
   logic [LW-1:0] level_ff, level_in;
   logic [CW-1:0] cell_x_ff, cell_x_in, cell_y_ff, cell_y_in;
   mbc_pkg::row_type row_c_ff, row_c_in, row_u_ff, row_u_in;
   logic [CW-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [1:0]    rsp_dir_ff, rsp_dir_in;
   logic          rsp_carved_ff, rsp_carved_in, rsp_fin_ff, rsp_fin_in;

   mbc_pkg::map_req_type map_req;
   mbc_pkg::row_type     map_rd_data;

   logic                       stk_wr_en, stk_rd_en;
   logic [mbc_pkg::CELL_W-1:0] stk_wr_addr, stk_rd_addr;
   mbc_pkg::cell_type          stk_wr_data, stk_rd_data;

   logic          out_free;
   logic [LW-1:0] level_dec, level_dec2;
   logic [CW-1:0] sat_x, sat_y;

   // neighbour evaluation
   logic [3:0]    open_nb;
   logic [2:0]    open_cnt, seen;
   logic [1:0]    pick, sel_dir;
   logic [CW-1:0] nxt_x, nxt_y;
   mbc_pkg::row_type base_row;

   mbc_visit_map u_map (
      .clock   (clock),
      .reset   (reset),
      .req     (map_req),
      .rd_data (map_rd_data)
   );

   mbc_stack_ram u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign level_dec  = level_ff - LW'(1);
   assign level_dec2 = level_ff - LW'(2);
   assign req_ready  = (state_ff == S_IDLE);

   // start cell saturation
   assign sat_x = (32'(start_x_ff) >= mbc_pkg::GRID_SIDE) ? MAX_COORD : start_x_ff;
   assign sat_y = (32'(start_y_ff) >= mbc_pkg::GRID_SIDE) ? MAX_COORD : start_y_ff;

   // unvisited neighbours of the current cell; down row comes straight from the map
   always_comb begin
      open_nb[0] = (cell_x_ff != '0) && !row_c_ff[cell_x_ff - CW'(1)];
      open_nb[1] = (cell_x_ff != MAX_COORD) && !row_c_ff[cell_x_ff + CW'(1)];
      open_nb[2] = (cell_y_ff != '0) && !row_u_ff[cell_x_ff];
      open_nb[3] = (cell_y_ff != MAX_COORD) && !map_rd_data[cell_x_ff];
      open_cnt   = 3'(open_nb[0]) + 3'(open_nb[1]) + 3'(open_nb[2]) + 3'(open_nb[3]);
   end

   // random pick modulo count
   always_comb begin
      case (open_cnt)
         3'd2:    pick = {1'b0, rnd_ff[0]};
         3'd3:    pick = rnd_mod3_ff;
         3'd4:    pick = rnd_ff[1:0];
         default: pick = 2'd0;
      endcase
   end

   // locate the picked entry in left, right, up, down order
   always_comb begin
      seen    = '0;
      sel_dir = mbc_pkg::DIR_LEFT;
      for (int i = 0; i < 4; i++) begin
         if (open_nb[i]) begin
            if (seen == {1'b0, pick})
               sel_dir = 2'(i);
            seen = seen + 3'd1;
         end
      end
   end

   // target cell and the row word it lives in
   always_comb begin
      case (sel_dir)
         mbc_pkg::DIR_LEFT: begin
            nxt_x = cell_x_ff - CW'(1); nxt_y = cell_y_ff; base_row = row_c_ff;
         end
         mbc_pkg::DIR_RIGHT: begin
            nxt_x = cell_x_ff + CW'(1); nxt_y = cell_y_ff; base_row = row_c_ff;
         end
         mbc_pkg::DIR_UP: begin
            nxt_x = cell_x_ff; nxt_y = cell_y_ff - CW'(1); base_row = row_u_ff;
         end
         default: begin
            nxt_x = cell_x_ff; nxt_y = cell_y_ff + CW'(1); base_row = map_rd_data;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      if (csr_wr_en) begin
         case (csr_index)
            mbc_pkg::CSR_START_X: start_x_in = csr_wr_data;
            mbc_pkg::CSR_START_Y: start_y_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      rnd_in      = rnd_ff;
      rnd_mod3_in = rnd_mod3_ff;
      level_in    = level_ff;
      cell_x_in   = cell_x_ff;
      cell_y_in   = cell_y_ff;
      row_c_in    = row_c_ff;
      row_u_in    = row_u_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_carved_in = rsp_carved_ff;
      rsp_fin_in    = rsp_fin_ff;

      map_req = '0;
      stk_wr_en   = 1'b0;
      stk_wr_addr = '0;
      stk_wr_data = '0;
      stk_rd_en   = 1'b0;
      stk_rd_addr = level_dec[mbc_pkg::CELL_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in     = req_mode;
               rnd_in      = req_random_byte;
               rnd_mod3_in = mbc_pkg::mod3_byte(req_random_byte);
               state_in    = S_LAUNCH;
            end
         end

         S_LAUNCH: begin
            if (mode_ff == mbc_pkg::MODE_START) begin
               // new maze: clear map, mark and push the start cell
               if (out_free) begin
                  map_req.clear_all = 1'b1;
                  map_req.wr_en     = 1'b1;
                  map_req.wr_row    = sat_y;
                  map_req.wr_data   = mbc_pkg::row_type'(1) << sat_x;
                  stk_wr_en   = 1'b1;
                  stk_wr_addr = '0;
                  stk_wr_data = {sat_y, sat_x};
                  level_in    = LW'(1);
                  rsp_valid_in  = 1'b1;
                  rsp_x_in      = sat_x;
                  rsp_y_in      = sat_y;
                  rsp_dir_in    = mbc_pkg::DIR_LEFT;
                  rsp_carved_in = 1'b0;
                  rsp_fin_in    = 1'b0;
                  state_in      = S_IDLE;
               end
            end else if (level_ff == '0) begin
               // empty stack reports finished
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_x_in      = '0;
                  rsp_y_in      = '0;
                  rsp_dir_in    = mbc_pkg::DIR_LEFT;
                  rsp_carved_in = 1'b0;
                  rsp_fin_in    = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               stk_rd_en = 1'b1;
               state_in  = S_TOP;
            end
         end

         S_TOP: begin
            // top of stack arrives, fetch its own row
            cell_x_in      = stk_rd_data[CW-1:0];
            cell_y_in      = stk_rd_data[mbc_pkg::CELL_W-1:CW];
            map_req.rd_en  = 1'b1;
            map_req.rd_row = stk_rd_data[mbc_pkg::CELL_W-1:CW];
            state_in       = S_ROWC;
         end

         S_ROWC: begin
            row_c_in       = map_rd_data;
            map_req.rd_en  = 1'b1;
            map_req.rd_row = cell_y_ff - CW'(1);
            state_in       = S_ROWU;
         end

         S_ROWU: begin
            row_u_in       = map_rd_data;
            map_req.rd_en  = 1'b1;
            map_req.rd_row = cell_y_ff + CW'(1);
            state_in       = S_EVAL;
         end

         S_EVAL: begin
            if (open_cnt != '0) begin
               // carve: mark target visited, push it, report the wall
               if (out_free) begin
                  map_req.wr_en   = 1'b1;
                  map_req.wr_row  = nxt_y;
                  map_req.wr_data = base_row | (mbc_pkg::row_type'(1) << nxt_x);
                  if (level_ff < LEVEL_FULL) begin
                     stk_wr_en   = 1'b1;
                     stk_wr_addr = level_ff[mbc_pkg::CELL_W-1:0];
                     stk_wr_data = {nxt_y, nxt_x};
                     level_in    = level_ff + LW'(1);
                  end
                  rsp_valid_in  = 1'b1;
                  rsp_x_in      = cell_x_ff;
                  rsp_y_in      = cell_y_ff;
                  rsp_dir_in    = sel_dir;
                  rsp_carved_in = 1'b1;
                  rsp_fin_in    = 1'b0;
                  state_in      = S_IDLE;
               end
            end else if (level_dec == '0) begin
               // last cell was a dead end: maze complete
               if (out_free) begin
                  level_in      = '0;
                  rsp_valid_in  = 1'b1;
                  rsp_x_in      = '0;
                  rsp_y_in      = '0;
                  rsp_dir_in    = mbc_pkg::DIR_LEFT;
                  rsp_carved_in = 1'b0;
                  rsp_fin_in    = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               // backtrack: pop and fetch the new top
               level_in    = level_dec;
               stk_rd_en   = 1'b1;
               stk_rd_addr = level_dec2[mbc_pkg::CELL_W-1:0];
               state_in    = S_TOP;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         start_x_ff   <= mbc_pkg::START_X_RESET;
         start_y_ff   <= mbc_pkg::START_Y_RESET;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      rnd_ff        <= rnd_in;
      rnd_mod3_ff   <= rnd_mod3_in;
      cell_x_ff     <= cell_x_in;
      cell_y_ff     <= cell_y_in;
      row_c_ff      <= row_c_in;
      row_u_ff      <= row_u_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_carved_ff <= rsp_carved_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_from_x    = rsp_x_ff;
   assign rsp_from_y    = rsp_y_ff;
   assign rsp_direction = rsp_dir_ff;
   assign rsp_carved    = rsp_carved_ff;
   assign rsp_finished  = rsp_fin_ff;

endmodule

[rtl/core/mbc_port_checker.sv]
// Port-level checks for maze_backtracker_carver_core, attached by bind.
// Uses mbc_pkg for field widths.

module mbc_port_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [mbc_pkg::COORD_W-1:0] rsp_from_x,
   input logic [mbc_pkg::COORD_W-1:0] rsp_from_y,
   input logic [1:0]                  rsp_direction,
   input logic                        rsp_carved,
   input logic                        rsp_finished
);

   // no result is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // one request at a time: busy the cycle after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   // a result is never both a carve and the finish marker
   a_carve_xor_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_carved && rsp_finished))
      else $error("carved and finished both set");

   // finish marker carries zero coordinates and direction
   a_finish_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |->
         rsp_from_x == '0 && rsp_from_y == '0 && rsp_direction == '0)
      else $error("finished result with nonzero payload");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_from_x) &&
         $stable(rsp_from_y) && $stable(rsp_direction) && $stable(rsp_carved) &&
         $stable(rsp_finished))
      else $error("stalled result changed");

endmodule

bind maze_backtracker_carver_core mbc_port_checker u_mbc_port_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_from_x    (rsp_from_x),
   .rsp_from_y    (rsp_from_y),
   .rsp_direction (rsp_direction),
   .rsp_carved    (rsp_carved),
   .rsp_finished  (rsp_finished)
);

[verif/tb_maze_backtracker_carver_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for maze_backtracker_carver_core: directed and random
// start/step requests, checked against an in-bench depth-first carving predictor.
// Depends on mbc_pkg and the maze_backtracker_carver_core RTL only.

module tb_maze_backtracker_carver_core;

   localparam int SIDE         = mbc_pkg::GRID_SIDE;
   localparam int CELLS        = mbc_pkg::CELL_COUNT;
   localparam int CW           = mbc_pkg::COORD_W;
   localparam int QUIET_LIMIT  = 20000;
   localparam int RANDOM_ITEMS = 500;

   // one expected wall report
   typedef struct packed {
      logic [CW-1:0] col;
      logic [CW-1:0] row;
      logic [1:0]    wall;
      logic          carved;
      logic          finished;
   } wall_report_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_mode;
   logic [mbc_pkg::RND_W-1:0]      req_random_byte;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [CW-1:0]                  rsp_from_x;
   logic [CW-1:0]                  rsp_from_y;
   logic [1:0]                     rsp_direction;
   logic                           rsp_carved;
   logic                           rsp_finished;
   logic                           csr_wr_en;
   logic [mbc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mbc_pkg::CSR_DATA_W-1:0] csr_wr_data;

   // predictor state: configured start cell, visited cells, carving trail
   logic [CW-1:0] cfg_col;
   logic [CW-1:0] cfg_row;
   bit            seen_cell [CELLS];
   int            trail [CELLS];
   int            trail_depth;

   wall_report_type wall_queue [$];
   int            mismatch_count = 0;
   bit            bursty = 1'b0;
   int            burst_left = 0;
   int            hold_left = 0;
   int            pattern_left = 0;
   logic [15:0]   ready_pattern = '1;
   int            quiet_cycles = 0;

   maze_backtracker_carver_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_random_byte (req_random_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_from_x      (rsp_from_x),
      .rsp_from_y      (rsp_from_y),
      .rsp_direction   (rsp_direction),
      .rsp_carved      (rsp_carved),
      .rsp_finished    (rsp_finished),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // expected result of one request; advances the predictor state
   task automatic predict_wall(input logic mode, input logic [7:0] rnd,
                               output wall_report_type res);
      int         sx, sy, here, x, y, n, pick;
      logic [1:0] dirs [4];
      int         cells [4];
      res = '0;
      if (mode == mbc_pkg::MODE_START) begin
         sx = (int'(cfg_col) >= SIDE) ? SIDE - 1 : int'(cfg_col);
         sy = (int'(cfg_row) >= SIDE) ? SIDE - 1 : int'(cfg_row);
         foreach (seen_cell[i]) seen_cell[i] = 1'b0;
         here = sy * SIDE + sx;
         seen_cell[here] = 1'b1;
         trail[0] = here;
         trail_depth = 1;
         res.col = sx[CW-1:0];
         res.row = sy[CW-1:0];
         return;
      end
      // backtrack over dead ends until the top cell has an open neighbor
      while (trail_depth > 0) begin
         here = trail[trail_depth - 1];
         x = here % SIDE;
         y = here / SIDE;
         n = 0;
         if (x > 0 && !seen_cell[here - 1]) begin
            dirs[n] = mbc_pkg::DIR_LEFT; cells[n] = here - 1; n++;
         end
         if (x < SIDE - 1 && !seen_cell[here + 1]) begin
            dirs[n] = mbc_pkg::DIR_RIGHT; cells[n] = here + 1; n++;
         end
         if (y > 0 && !seen_cell[here - SIDE]) begin
            dirs[n] = mbc_pkg::DIR_UP; cells[n] = here - SIDE; n++;
         end
         if (y < SIDE - 1 && !seen_cell[here + SIDE]) begin
            dirs[n] = mbc_pkg::DIR_DOWN; cells[n] = here + SIDE; n++;
         end
         if (n == 0) begin
            trail_depth--;
            continue;
         end
         pick = int'(rnd) % n;
         seen_cell[cells[pick]] = 1'b1;
         if (trail_depth < CELLS) begin
            trail[trail_depth] = cells[pick];
            trail_depth++;
         end
         res.col = x[CW-1:0];
         res.row = y[CW-1:0];
         res.wall = dirs[pick];
         res.carved = 1'b1;
         return;
      end
      // stack empty: maze complete
      res.finished = 1'b1;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // offer one request, honoring the burst/gap pattern, and queue its prediction
   task automatic send_request(input logic mode, input logic [7:0] rnd);
      wall_report_type res;
      int              gap;
      if (bursty) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left--;
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_random_byte <= rnd;
      do @(posedge clock); while (!req_ready);
      predict_wall(mode, rnd, res);
      wall_queue = {wall_queue, res};
   endtask

   // stop offering and wait until every expected result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (wall_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write both start registers; only called with the block idle
   task automatic write_config(input logic [CW-1:0] col, input logic [CW-1:0] row);
      csr_wr_en   <= 1'b1;
      csr_index   <= mbc_pkg::CSR_START_X;
      csr_wr_data <= col;
      @(posedge clock);
      cfg_col = col;
      csr_index   <= mbc_pkg::CSR_START_Y;
      csr_wr_data <= row;
      @(posedge clock);
      cfg_row = row;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CW-1:0] pick_coord();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return CW'(SIDE - 1);
         default: return CW'($urandom_range(0, SIDE - 1));
      endcase
   endfunction

   // steps with an empty stack report finished
   task automatic test_step_before_start();
      send_request(mbc_pkg::MODE_STEP, 8'd0);
      send_request(mbc_pkg::MODE_STEP, 8'd255);
   endtask

   // start at the reset position and walk a few steps
   task automatic test_start_at_reset_position();
      send_request(mbc_pkg::MODE_START, 8'd0);
      send_request(mbc_pkg::MODE_STEP, 8'd0);
      send_request(mbc_pkg::MODE_STEP, 8'd1);
      send_request(mbc_pkg::MODE_STEP, 8'd2);
      send_request(mbc_pkg::MODE_STEP, 8'd3);
      send_request(mbc_pkg::MODE_STEP, 8'd255);
   endtask

   // starts in each corner, where neighbors fall off the grid
   task automatic test_grid_corners();
      logic [CW-1:0] cols [4];
      logic [CW-1:0] rows [4];
      cols = '{'0, CW'(SIDE - 1), CW'(SIDE - 1), '0};
      rows = '{'0, CW'(SIDE - 1), '0, CW'(SIDE - 1)};
      for (int c = 0; c < 4; c++) begin
         wait_drained();
         write_config(cols[c], rows[c]);
         send_request(mbc_pkg::MODE_START, 8'd255);
         send_request(mbc_pkg::MODE_STEP, 8'd0);
         send_request(mbc_pkg::MODE_STEP, 8'd255);
      end
   endtask

   // a start in the middle of a maze clears the map
   task automatic test_restart_mid_maze();
      send_request(mbc_pkg::MODE_START, 8'd7);
      send_request(mbc_pkg::MODE_STEP, 8'd170);
      send_request(mbc_pkg::MODE_START, 8'd85);
      send_request(mbc_pkg::MODE_STEP, 8'd1);
   endtask

   // receiver holds off while requests keep coming; block must stall its input
   task automatic test_long_output_stall();
      wait_drained();
      bursty = 1'b0;
      hold_left = 300;
      send_request(mbc_pkg::MODE_START, 8'($urandom_range(0, 255)));
      repeat (11) send_request(mbc_pkg::MODE_STEP, 8'($urandom_range(0, 255)));
      wait_drained();
   endtask

   // mostly start-then-steps sequences, some random noise, config changes
   task automatic test_random_mazes();
      int sent, steps;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_drained();
            write_config(pick_coord(), pick_coord());
         end
         bursty = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 9) == 0) begin
            steps = $urandom_range(1, 5);
            repeat (steps) send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            sent += steps;
         end else begin
            steps = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 160)
                                                 : $urandom_range(5, 40);
            send_request(mbc_pkg::MODE_START, 8'($urandom_range(0, 255)));
            repeat (steps) send_request(mbc_pkg::MODE_STEP, 8'($urandom_range(0, 255)));
            sent += steps + 1;
         end
         if ($urandom_range(0, 5) == 0) wait_drained();
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_mode        = mbc_pkg::MODE_START;
      req_random_byte = '0;
      rsp_ready       = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = mbc_pkg::CSR_START_X;
      csr_wr_data     = '0;
      cfg_col         = mbc_pkg::START_X_RESET;
      cfg_row         = mbc_pkg::START_Y_RESET;
      trail_depth     = 0;
      foreach (seen_cell[i]) seen_cell[i] = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_step_before_start();
      test_start_at_reset_position();
      test_restart_mid_maze();
      test_grid_corners();
      test_long_output_stall();
      test_random_mazes();

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // receiver: long hold when asked, otherwise a rotating ready pattern
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         if (pattern_left == 0) begin
            pattern_left = 16;
            ready_pattern = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom());
         end
         rsp_ready <= ready_pattern[0];
         ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
         pattern_left--;
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      wall_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (wall_queue.size() == 0) begin
            report_mismatch("unrequested result", int'(rsp_finished), 0);
         end else begin
            want = wall_queue.pop_front();
            if (rsp_from_x !== want.col)
               report_mismatch("from_x", int'(rsp_from_x), int'(want.col));
            if (rsp_from_y !== want.row)
               report_mismatch("from_y", int'(rsp_from_y), int'(want.row));
            if (rsp_direction !== want.wall)
               report_mismatch("direction", int'(rsp_direction), int'(want.wall));
            if (rsp_carved !== want.carved)
               report_mismatch("carved", int'(rsp_carved), int'(want.carved));
            if (rsp_finished !== want.finished)
               report_mismatch("finished", int'(rsp_finished), int'(want.finished));
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
